>>> src/fpa_pkg.sv
// Shared types and codes for the fit-policy partition allocator.
// No dependencies; used by fpa_cell and fit_policy_partition_allocator.
`default_nettype none

package fpa_pkg;

   // request opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // fit policy codes (the unused code behaves as first fit)
   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   // register indexes on the CSR port
   localparam logic REG_FIT_POLICY        = 1'b0;
   localparam logic REG_ACTIVE_PARTITIONS = 1'b1;

   // register reset values
   localparam logic [1:0] FIT_POLICY_RESET        = POLICY_FIRST;
   localparam logic [3:0] ACTIVE_PARTITIONS_RESET = 4'd8;

   // control broadcast to each cell
   typedef struct packed {
      logic [1:0] policy;    // fit policy in force
      logic       in_range;  // cell lies inside the scanned range
      logic       write;     // cell takes the write data this cycle
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> src/fpa_cell.sv
// One partition cell: holds the free size of a partition and updates the
// candidate handed along the chain. Depends on fpa_pkg.
`default_nettype none

module fpa_cell #(
   parameter int SIZE_BITS  = 16,
   parameter int IDX_W      = 3,
   parameter int CELL_INDEX = 0
) (
   input  wire                      clock,
   input  wire                      reset,
   input  fpa_pkg::cell_ctl_type    ctl,
   input  wire  [SIZE_BITS-1:0]     req_size,
   input  wire  [SIZE_BITS-1:0]     wr_data,
   input  wire                      cand_in_found,
   input  wire  [IDX_W-1:0]         cand_in_idx,
   input  wire  [SIZE_BITS-1:0]     cand_in_size,
   output logic                     cand_out_found,
   output logic [IDX_W-1:0]         cand_out_idx,
   output logic [SIZE_BITS-1:0]     cand_out_size
);

   logic [SIZE_BITS-1:0] free_ff;
   logic [SIZE_BITS-1:0] free_in;
   logic                 found_ff;
   logic                 found_in;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     idx_in;
   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS-1:0] size_in;
   logic                 fits;
   logic                 take;

   // free size store
   assign free_in = ctl.write ? wr_data : free_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
      end else begin
         free_ff <= free_in;
      end
   end

   // does this cell replace the incoming candidate
   assign fits = ctl.in_range && (free_ff >= req_size);

   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (!cand_in_found) begin
            take = 1'b1;
         end else begin
            unique case (ctl.policy)
               fpa_pkg::POLICY_BEST:  take = (free_ff < cand_in_size);
               fpa_pkg::POLICY_WORST: take = (free_ff > cand_in_size);
               default:               take = 1'b0;
            endcase
         end
      end
   end

   assign found_in = cand_in_found | take;
   assign idx_in   = take ? IDX_W'(CELL_INDEX) : cand_in_idx;
   assign size_in  = take ? free_ff : cand_in_size;

   // candidate handed to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      size_ff <= size_in;
   end

   assign cand_out_found = found_ff;
   assign cand_out_idx   = idx_ff;
   assign cand_out_size  = size_ff;

endmodule

`default_nettype wire

>>> src/fit_policy_partition_allocator.sv
// Top level of the fit-policy partition allocator: CSR port, control
// sequencer, row of fpa_cell instances. Depends on fpa_pkg and fpa_cell.
//
// Usage:
//  - req_* carries one request: a load (opcode 0) writes the free size of
//    partition req_partition_index; an allocate (opcode 1) asks for
//    req_size_value units from a partition chosen by the fit policy.
//  - rsp_* returns one response per request: grant flag, partition index
//    and the free size left in that partition (index and size 0 if refused).
//  - csr_*: register 0 (byte 0) fit policy, register 1 (byte 4) number of
//    partitions scanned. Write only while no request is in flight.
//  - Each partition lives in a cell; an allocate sends a candidate down the
//    row one cell per cycle during the scan, then commits the update and
//    loads the response register in the finish state. A load goes straight
//    to the finish state. A new request is accepted the cycle after a
//    response is loaded, so no request is taken while another is still
//    being scanned or committed.
//  - Reset: all partitions have free size 0, first fit, 8 partitions active.
//  - If rsp_ready is low, the response is held; a following request can be
//    accepted and scanned, and waits to commit until the response is taken.
`default_nettype none

module fit_policy_partition_allocator #(
   parameter int NUM_PARTITIONS = 8,
   parameter int SIZE_BITS      = 16
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_opcode,
   input  wire  [2:0]  req_partition_index,
   input  wire  [15:0] req_size_value,
   // response channel
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_granted,
   output logic [2:0]  rsp_chosen_index,
   output logic [15:0] rsp_remaining_size,
   // CSR port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
   localparam int CNT_W = IDX_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // ------------------------------------------------------------------
   // CSR registers
   logic [1:0] policy_ff;
   logic [1:0] policy_in;
   logic [3:0] active_ff;
   logic [3:0] active_in;
   logic       csr_wr;
   logic       csr_reg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = csr_paddr[2];

   assign policy_in = (csr_wr && csr_reg == fpa_pkg::REG_FIT_POLICY) ?
                      csr_pwdata[1:0] : policy_ff;
   assign active_in = (csr_wr && csr_reg == fpa_pkg::REG_ACTIVE_PARTITIONS) ?
                      csr_pwdata[3:0] : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= fpa_pkg::FIT_POLICY_RESET;
         active_ff <= fpa_pkg::ACTIVE_PARTITIONS_RESET;
      end else begin
         policy_ff <= policy_in;
         active_ff <= active_in;
      end
   end

   always_comb begin
      unique case (csr_reg)
         fpa_pkg::REG_FIT_POLICY:        csr_prdata = {30'd0, policy_ff};
         fpa_pkg::REG_ACTIVE_PARTITIONS: csr_prdata = {28'd0, active_ff};
      endcase
   end

   // ------------------------------------------------------------------
   // request capture and sequencer
   logic [1:0]           state_ff;
   logic [1:0]           state_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic                 op_ff;
   logic [2:0]           pidx_ff;
   logic [SIZE_BITS-1:0] req_size_ff;
   logic [31:0]          size_wide;
   logic                 req_fire;
   logic                 commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign commit    = (state_ff == ST_FINISH) && (!rsp_valid || rsp_ready);
   assign size_wide = 32'(req_size_value);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_opcode == fpa_pkg::OP_LOAD) ? ST_FINISH : ST_SCAN;
            end
            cnt_in = '0;
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(NUM_PARTITIONS - 1)) begin
               state_in = ST_FINISH;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff       <= req_opcode;
         pidx_ff     <= req_partition_index;
         req_size_ff <= size_wide[SIZE_BITS-1:0];
      end
   end

   // ------------------------------------------------------------------
   // row of partition cells
   logic                 cand_found [NUM_PARTITIONS];
   logic [IDX_W-1:0]     cand_idx   [NUM_PARTITIONS];
   logic [SIZE_BITS-1:0] cand_size  [NUM_PARTITIONS];
   logic [NUM_PARTITIONS-1:0] wr_sel;
   logic [SIZE_BITS-1:0] wr_data;
   logic                 load_ok;
   logic                 last_found;
   logic [IDX_W-1:0]     last_idx;
   logic [SIZE_BITS-1:0] last_size;

   assign last_found = cand_found[NUM_PARTITIONS-1];
   assign last_idx   = cand_idx[NUM_PARTITIONS-1];
   assign last_size  = cand_size[NUM_PARTITIONS-1];
   assign load_ok    = 32'(pidx_ff) < 32'(NUM_PARTITIONS);
   assign wr_data    = (op_ff == fpa_pkg::OP_LOAD) ? req_size_ff
                                                   : (last_size - req_size_ff);

   genvar j;
   generate
      for (j = 0; j < NUM_PARTITIONS; j++) begin : g_cell
         fpa_pkg::cell_ctl_type ctl;
         logic                  prev_found;
         logic [IDX_W-1:0]      prev_idx;
         logic [SIZE_BITS-1:0]  prev_size;

         // pick this cell for the commit write
         assign wr_sel[j] = commit &&
            ((op_ff == fpa_pkg::OP_LOAD) ? (load_ok && 32'(pidx_ff) == 32'(j))
                                         : (last_found && last_idx == IDX_W'(j)));

         assign ctl.policy   = policy_ff;
         assign ctl.in_range = {28'd0, active_ff} > 32'(j);
         assign ctl.write    = wr_sel[j];

         if (j == 0) begin : g_head
            assign prev_found = 1'b0;
            assign prev_idx   = '0;
            assign prev_size  = '0;
         end else begin : g_link
            assign prev_found = cand_found[j-1];
            assign prev_idx   = cand_idx[j-1];
            assign prev_size  = cand_size[j-1];
         end

         fpa_cell #(
            .SIZE_BITS  (SIZE_BITS),
            .IDX_W      (IDX_W),
            .CELL_INDEX (j)
         ) u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctl            (ctl),
            .req_size       (req_size_ff),
            .wr_data        (wr_data),
            .cand_in_found  (prev_found),
            .cand_in_idx    (prev_idx),
            .cand_in_size   (prev_size),
            .cand_out_found (cand_found[j]),
            .cand_out_idx   (cand_idx[j]),
            .cand_out_size  (cand_size[j])
         );
      end
   endgenerate

   // ------------------------------------------------------------------
   // response register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        granted;
   logic [31:0] pick_wide;
   logic [31:0] rem_wide;

   assign granted   = (op_ff == fpa_pkg::OP_LOAD) ? load_ok : last_found;
   assign pick_wide = (op_ff == fpa_pkg::OP_LOAD) ? 32'(pidx_ff) : 32'(last_idx);
   assign rem_wide  = 32'(wr_data);

   assign rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_granted        <= granted;
         rsp_chosen_index   <= granted ? pick_wide[2:0] : 3'd0;
         rsp_remaining_size <= granted ? rem_wide[15:0] : 16'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // a committed allocate never takes more than the partition holds
   a_fit_ok: assert property (@(posedge clock) disable iff (reset)
      (commit && op_ff == fpa_pkg::OP_ALLOC && last_found) |->
         (last_size >= req_size_ff))
      else $error("chosen partition smaller than the request");

   // at most one cell is written per commit
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_sel))
      else $error("more than one partition written");

   // writes only happen in the commit cycle
   a_write_commit: assert property (@(posedge clock) disable iff (reset)
      (wr_sel != '0) |-> (state_ff == ST_FINISH))
      else $error("partition written outside commit");

   // refused responses carry zero index and size
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_granted) |->
         (rsp_chosen_index == 3'd0 && rsp_remaining_size == 16'd0))
      else $error("refused response with nonzero fields");

   // scan counter is idle outside the scan
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |-> (cnt_ff == '0))
      else $error("scan counter running outside scan");
`endif

endmodule

`default_nettype wire

>>> tb/tb_fit_policy_partition_allocator.sv
// Self-checking testbench for fit_policy_partition_allocator: directed table, then
// random phases under several fit policies and scan widths, with random idling on both sides.
// Depends on fpa_pkg and the allocator RTL.

module tb_fit_policy_partition_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PARTS      = 8;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_REQUESTS = 75;
   localparam int SETTLE_CYCLES  = 20;   // idle time after draining, before the report
   localparam int REPORT_LIMIT   = 10;
   localparam logic [1:0] POLICY_UNUSED = 2'd3;

   typedef struct packed {
      logic        granted;
      logic [2:0]  chosen_index;
      logic [15:0] remaining_size;
   } alloc_result_type;

   typedef enum logic {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic             csr_reg;
      logic [3:0]       csr_value;
      logic             opcode;
      logic [2:0]       pidx;
      logic [15:0]      size;
      logic             typed;     // expected outcome given in the row
      alloc_result_type outcome;
   } stim_row_type;

   localparam alloc_result_type NO_GRANT = '0;

   // directed table; rows without a typed outcome go through the predictor
   localparam stim_row_type DIRECTED [30] = '{
      // empty partitions: zero request fits, anything else is refused
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd0, 16'd0,
        1'b1, '{1'b1, 3'd0, 16'd0}},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd5, 16'd1,
        1'b1, NO_GRANT},
      // fill partitions
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_LOAD, 3'd0, 16'd100,
        1'b1, '{1'b1, 3'd0, 16'd100}},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_LOAD, 3'd1, 16'd50,
        1'b1, '{1'b1, 3'd1, 16'd50}},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_LOAD, 3'd2, 16'd300,
        1'b1, '{1'b1, 3'd2, 16'd300}},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_LOAD, 3'd3, 16'd60,
        1'b1, '{1'b1, 3'd3, 16'd60}},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_LOAD, 3'd5, 16'd200,
        1'b1, '{1'b1, 3'd5, 16'd200}},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_LOAD, 3'd7, 16'd65535,
        1'b1, '{1'b1, 3'd7, 16'd65535}},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd0, 16'd55,
        1'b0, NO_GRANT},
      // best fit, including an exact fit
      '{ROW_CSR, fpa_pkg::REG_FIT_POLICY, {2'b00, fpa_pkg::POLICY_BEST},
        fpa_pkg::OP_LOAD, 3'd0, 16'd0, 1'b0, NO_GRANT},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd2, 16'd55,
        1'b0, NO_GRANT},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd0, 16'd45,
        1'b0, NO_GRANT},
      // worst fit
      '{ROW_CSR, fpa_pkg::REG_FIT_POLICY, {2'b00, fpa_pkg::POLICY_WORST},
        fpa_pkg::OP_LOAD, 3'd0, 16'd0, 1'b0, NO_GRANT},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd0, 16'd100,
        1'b0, NO_GRANT},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd7, 16'd0,
        1'b0, NO_GRANT},
      // unused policy code behaves as first fit
      '{ROW_CSR, fpa_pkg::REG_FIT_POLICY, {2'b00, POLICY_UNUSED},
        fpa_pkg::OP_LOAD, 3'd0, 16'd0, 1'b0, NO_GRANT},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd0, 16'd10,
        1'b0, NO_GRANT},
      // nothing scanned: every allocate refused, loads still land
      '{ROW_CSR, fpa_pkg::REG_ACTIVE_PARTITIONS, 4'd0,
        fpa_pkg::OP_LOAD, 3'd0, 16'd0, 1'b0, NO_GRANT},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd0, 16'd0,
        1'b1, NO_GRANT},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_LOAD, 3'd6, 16'd1234,
        1'b1, '{1'b1, 3'd6, 16'd1234}},
      // single partition scanned
      '{ROW_CSR, fpa_pkg::REG_ACTIVE_PARTITIONS, 4'd1,
        fpa_pkg::OP_LOAD, 3'd0, 16'd0, 1'b0, NO_GRANT},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd0, 16'd1,
        1'b0, NO_GRANT},
      // oversized scan count saturates, back to best fit
      '{ROW_CSR, fpa_pkg::REG_ACTIVE_PARTITIONS, 4'd15,
        fpa_pkg::OP_LOAD, 3'd0, 16'd0, 1'b0, NO_GRANT},
      '{ROW_CSR, fpa_pkg::REG_FIT_POLICY, {2'b00, fpa_pkg::POLICY_BEST},
        fpa_pkg::OP_LOAD, 3'd0, 16'd0, 1'b0, NO_GRANT},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd0, 16'd1234,
        1'b0, NO_GRANT},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd0, 16'd65535,
        1'b0, NO_GRANT},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_LOAD, 3'd4, 16'd65535,
        1'b1, '{1'b1, 3'd4, 16'd65535}},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd0, 16'd65535,
        1'b0, NO_GRANT},
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_LOAD, 3'd7, 16'd0,
        1'b1, '{1'b1, 3'd7, 16'd0}},
      // tie among empty partitions goes to the lowest index
      '{ROW_REQUEST, fpa_pkg::REG_FIT_POLICY, 4'd0, fpa_pkg::OP_ALLOC, 3'd3, 16'd0,
        1'b0, NO_GRANT}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = fpa_pkg::OP_LOAD;
   logic [2:0]  req_partition_index = '0;
   logic [15:0] req_size_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_granted;
   logic [2:0]  rsp_chosen_index;
   logic [15:0] rsp_remaining_size;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fit_policy_partition_allocator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_partition_index(req_partition_index),
      .req_size_value     (req_size_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_granted        (rsp_granted),
      .rsp_chosen_index   (rsp_chosen_index),
      .rsp_remaining_size (rsp_remaining_size),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #5ns clock = ~clock;

   // predictor state: free size per partition plus the register copies
   logic [15:0]      part_free [NUM_PARTS];
   logic [1:0]       policy_cfg;
   logic [3:0]       active_cfg;
   alloc_result_type pending_outcomes [$];

   int gap_max = 5;
   int stall_max = 5;
   int stall_left = 0;
   int mismatch_count = 0;
   int load_count = 0;
   int alloc_count = 0;
   int refused_count = 0;
   int csr_write_count = 0;
   int cycle_count = 0;

   // applies one request to the free-size table and returns its outcome
   function automatic alloc_result_type place_request(input logic op,
                                                      input logic [2:0] pidx,
                                                      input logic [15:0] size);
      alloc_result_type outcome;
      int scan;
      int pick;
      bit found;
      outcome = NO_GRANT;
      if (op == fpa_pkg::OP_LOAD) begin
         part_free[pidx] = size;
         outcome = '{1'b1, pidx, size};
         return outcome;
      end
      scan = (active_cfg > NUM_PARTS) ? NUM_PARTS : int'(active_cfg);
      found = 1'b0;
      pick = 0;
      for (int j = 0; j < scan; j++) begin
         if (part_free[j] >= size) begin
            if (!found) begin
               found = 1'b1;
               pick = j;
            end else if (policy_cfg == fpa_pkg::POLICY_BEST &&
                         part_free[j] < part_free[pick]) begin
               pick = j;
            end else if (policy_cfg == fpa_pkg::POLICY_WORST &&
                         part_free[j] > part_free[pick]) begin
               pick = j;
            end
         end
      end
      if (found) begin
         part_free[pick] = part_free[pick] - size;
         outcome = '{1'b1, 3'(pick), part_free[pick]};
      end
      return outcome;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("MISMATCH @%0t: %s", $realtime, what);
      end
   endtask

   // one request on the input channel; valid stays up across back-to-back requests
   task automatic send_request(input logic op, input logic [2:0] pidx, input logic [15:0] size,
                               input logic typed, input alloc_result_type typed_outcome);
      alloc_result_type outcome;
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_partition_index <= pidx;
      req_size_value <= size;
      do @(posedge clock); while (!req_ready);
      outcome = place_request(op, pidx, size);
      pending_outcomes.push_back(typed ? typed_outcome : outcome);
      if (op == fpa_pkg::OP_LOAD) begin
         load_count++;
      end else begin
         alloc_count++;
      end
   endtask

   // stop sending and wait for every outstanding response
   task automatic drain_requests();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // register write, then read back; only called with nothing in flight
   task automatic write_csr(input logic reg_sel, input logic [3:0] value);
      logic [31:0] readback;
      logic [31:0] want;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= {28'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_sel == fpa_pkg::REG_FIT_POLICY) begin
         policy_cfg = value[1:0];
      end else begin
         active_cfg = value;
      end
      csr_write_count++;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      want = (reg_sel == fpa_pkg::REG_FIT_POLICY) ? {30'd0, policy_cfg} : {28'd0, active_cfg};
      if (readback !== want) begin
         note_mismatch($sformatf("csr reg %0d read %0h, expected %0h", reg_sel, readback, want));
      end
   endtask

   // response side: random stalls, compare against the oldest expected outcome
   always @(posedge clock) begin
      alloc_result_type seen;
      alloc_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_granted, rsp_chosen_index, rsp_remaining_size};
            if (pending_outcomes.size() == 0) begin
               note_mismatch($sformatf("unexpected response g=%0b idx=%0d rem=%0d",
                                       seen.granted, seen.chosen_index, seen.remaining_size));
            end else begin
               want = pending_outcomes.pop_front();
               if (seen.granted !== want.granted || seen.chosen_index !== want.chosen_index ||
                   seen.remaining_size !== want.remaining_size) begin
                  note_mismatch($sformatf(
                     "got g=%0b idx=%0d rem=%0d, expected g=%0b idx=%0d rem=%0d",
                     seen.granted, seen.chosen_index, seen.remaining_size,
                     want.granted, want.chosen_index, want.remaining_size));
               end
               if (!want.granted) begin
                  refused_count++;
               end
            end
            stall_left = $urandom_range(0, stall_max);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("fit_policy_partition_allocator regression: fail");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      logic         op;
      logic [2:0]   pidx;
      logic [15:0]  size;
      logic [3:0]   active;
      int           sel;
      foreach (part_free[i]) part_free[i] = '0;
      policy_cfg = fpa_pkg::FIT_POLICY_RESET;
      active_cfg = fpa_pkg::ACTIVE_PARTITIONS_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < $size(DIRECTED); i++) begin
         row = DIRECTED[i];
         if (row.kind == ROW_CSR) begin
            drain_requests();
            write_csr(row.csr_reg, row.csr_value);
         end else begin
            send_request(row.opcode, row.pidx, row.size, row.typed, row.outcome);
         end
      end

      // random phases, each under a fresh register setting and idling mix
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_requests();
         active = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
         write_csr(fpa_pkg::REG_FIT_POLICY, {2'b00, 2'($urandom_range(0, 3))});
         write_csr(fpa_pkg::REG_ACTIVE_PARTITIONS, active);
         gap_max = (phase % 2 == 1) ? 0 : 5;
         stall_max = (phase % 3 == 1) ? 0 : 5;
         for (int k = 0; k < PHASE_REQUESTS; k++) begin
            if ($urandom_range(0, 39) == 0) begin
               drain_requests();
            end
            sel = $urandom_range(0, 7);
            pidx = 3'($urandom_range(0, NUM_PARTS - 1));
            if ($urandom_range(0, 9) < 3) begin
               // loads: mostly modest sizes, some repeated values for ties
               op = fpa_pkg::OP_LOAD;
               if (sel == 0) begin
                  size = 16'($urandom_range(0, 65535));
               end else if (sel <= 2) begin
                  size = 16'($urandom_range(0, 3) * 100);
               end else begin
                  size = 16'($urandom_range(0, 2000));
               end
            end else begin
               // allocates: small asks, exact fits, zero and full-range sizes
               op = fpa_pkg::OP_ALLOC;
               if (sel == 0) begin
                  size = 16'($urandom_range(0, 65535));
               end else if (sel == 1) begin
                  size = part_free[$urandom_range(0, NUM_PARTS - 1)];
               end else if (sel == 2) begin
                  size = '0;
               end else begin
                  size = 16'($urandom_range(1, 400));
               end
            end
            send_request(op, pidx, size, 1'b0, NO_GRANT);
         end
      end

      drain_requests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d loads and %0d allocates (%0d refused) over %0d register writes,",
               load_count, alloc_count, refused_count, csr_write_count);
      $display("all four policy codes and scan counts 0, 1, 8 and 15; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("fit_policy_partition_allocator regression: pass");
      end else begin
         $display("fit_policy_partition_allocator regression: fail");
      end
      $finish;
   end

endmodule

>>> fit_policy_partition_allocator.f
src/fpa_pkg.sv
src/fpa_cell.sv
src/fit_policy_partition_allocator.sv
tb/tb_fit_policy_partition_allocator.sv
